// File: rtl/bpc_pkg.sv
package bpc_pkg;

  localparam int RawW      = 24;
  localparam int ScW       = 31;
  localparam int NumRegs   = 8;
  localparam int CfgAddrW  = 5;
  localparam int CfgDataW  = 32;
  localparam int NumStages = 9;

  // round(2^48 / 253952): 16x oversampling scale as a Q.48 reciprocal
  localparam logic signed [31:0] ScaleRecip = 32'sd1108378657;

  localparam logic signed [24:0] Half24 = 25'sd8388608;
  localparam logic signed [18:0] Half17 = 19'sd131072;
  localparam logic signed [16:0] Half15 = 17'sd32768;

  localparam logic signed [47:0] SatMax = 48'sd2147483647;
  localparam logic signed [47:0] SatMin = -48'sd2147483648;

  typedef enum logic [2:0] {
    RegTempCoeffs = 3'd0,
    RegPressOffset = 3'd1,
    RegPressLin = 3'd2,
    RegTempCross = 3'd3,
    RegCrossLin = 3'd4,
    RegPressQuad = 3'd5,
    RegCrossQuad = 3'd6,
    RegPressCubic = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coeff_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [47:0] v);
    sat_t r;
    if (v > SatMax) begin
      r.value = 32'sh7fffffff;
      r.clip  = 1'b1;
    end else if (v < SatMin) begin
      r.value = 32'sh80000000;
      r.clip  = 1'b1;
    end else begin
      r.value = 32'(v);
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/bpc_regs.sv
module bpc_regs import bpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output coeff_t              coeff_o
);

  reg_idx_e    idx;
  logic        wr_en;
  logic [23:0] temp_coeffs_q;
  logic [19:0] press_offset_q;
  logic [19:0] press_lin_q;
  logic [15:0] temp_cross_q;
  logic [15:0] cross_lin_q;
  logic [15:0] press_quad_q;
  logic [15:0] cross_quad_q;
  logic [15:0] press_cubic_q;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q  <= '0;
      press_offset_q <= '0;
      press_lin_q    <= '0;
      temp_cross_q   <= '0;
      cross_lin_q    <= '0;
      press_quad_q   <= '0;
      cross_quad_q   <= '0;
      press_cubic_q  <= '0;
    end else if (wr_en) begin
      case (idx)
        RegTempCoeffs:  temp_coeffs_q  <= pwdata[23:0];
        RegPressOffset: press_offset_q <= pwdata[19:0];
        RegPressLin:    press_lin_q    <= pwdata[19:0];
        RegTempCross:   temp_cross_q   <= pwdata[15:0];
        RegCrossLin:    cross_lin_q    <= pwdata[15:0];
        RegPressQuad:   press_quad_q   <= pwdata[15:0];
        RegCrossQuad:   cross_quad_q   <= pwdata[15:0];
        RegPressCubic:  press_cubic_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegTempCoeffs:  prdata = 32'(temp_coeffs_q);
      RegPressOffset: prdata = 32'(press_offset_q);
      RegPressLin:    prdata = 32'(press_lin_q);
      RegTempCross:   prdata = 32'(temp_cross_q);
      RegCrossLin:    prdata = 32'(cross_lin_q);
      RegPressQuad:   prdata = 32'(press_quad_q);
      RegCrossQuad:   prdata = 32'(cross_quad_q);
      RegPressCubic:  prdata = 32'(press_cubic_q);
      default:        prdata = '0;
    endcase
  end

  assign coeff_o.c0  = $signed(temp_coeffs_q[23:12]);
  assign coeff_o.c1  = $signed(temp_coeffs_q[11:0]);
  assign coeff_o.c00 = $signed(press_offset_q);
  assign coeff_o.c10 = $signed(press_lin_q);
  assign coeff_o.c01 = $signed(temp_cross_q);
  assign coeff_o.c11 = $signed(cross_lin_q);
  assign coeff_o.c20 = $signed(press_quad_q);
  assign coeff_o.c21 = $signed(cross_quad_q);
  assign coeff_o.c30 = $signed(press_cubic_q);

endmodule

// File: rtl/bpc_pipe_ctrl.sv
module bpc_pipe_ctrl import bpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [NumStages-1:0] stage_en_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] shifted;

  // a stage loads when it is empty or the next one moves on
  always_comb begin
    stage_en_o[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en_o[k] = !valid_q[k] || stage_en_o[k+1];
    end
  end

  assign shifted = {valid_q[NumStages-2:0], in_valid_i};
  assign valid_d = (stage_en_o & shifted) | (~stage_en_o & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_en_o[0];
  assign out_valid_o = valid_q[NumStages-1];

`ifndef SYNTHESIS
  a_ready_with_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q != {NumStages{1'b1}}) |-> in_ready_o)
    else $error("input stalled with an empty stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted beat missing from first stage");

  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(valid_q) == $countones($past(valid_q))
      + int'($past(in_valid_i && in_ready_o))
      - int'($past(out_valid_o && out_ready_i))))
    else $error("beat lost or duplicated in pipeline");
`endif

endmodule

// File: rtl/bpc_datapath.sv
module bpc_datapath import bpc_pkg::*; (
  input  logic                    clk_i,
  input  logic [NumStages-1:0]    en_i,
  input  coeff_t                  coeff_i,
  input  logic signed [RawW-1:0]  raw_pressure_i,
  input  logic signed [RawW-1:0]  raw_temperature_i,
  output logic signed [31:0]      temperature_q_o,
  output logic signed [31:0]      pressure_q_o,
  output logic                    saturated_o
);

  // stage 0: scale products
  logic signed [55:0] s0_pm_q, s0_tm_q;
  // stage 1: Q.24 scaled readings
  logic signed [ScW-1:0] s1_psc_q, s1_tsc_q;
  // stage 2: coefficient products
  logic signed [46:0] s2_m30_q, s2_m21_q, s2_mt01_q;
  logic signed [61:0] s2_mtp_q;
  logic signed [42:0] s2_mt1_q;
  logic signed [ScW-1:0] s2_psc_q;
  // stage 3: a, d, e, t
  logic signed [46:0] s3_a_q, s3_d_q, s3_mt01_q;
  logic signed [35:0] s3_e_q;
  logic signed [43:0] s3_t_q;
  logic signed [ScW-1:0] s3_psc_q;
  // stage 4: split products
  logic signed [55:0] s4_mal_q;
  logic signed [53:0] s4_mah_q;
  logic signed [60:0] s4_mdl_q;
  logic signed [58:0] s4_mdh_q;
  logic signed [46:0] s4_mt01_q;
  logic signed [ScW-1:0] s4_psc_q;
  sat_t s4_temp_q;
  // stage 5: b, e*d
  logic signed [51:0] s5_b_q;
  logic signed [56:0] s5_qed_q;
  logic signed [46:0] s5_mt01_q;
  logic signed [ScW-1:0] s5_psc_q;
  sat_t s5_temp_q;
  // stage 6: psc*b halves, partial sum
  logic signed [55:0] s6_mbl_q;
  logic signed [58:0] s6_mbh_q;
  logic signed [57:0] s6_sum_q;
  sat_t s6_temp_q;
  // stage 7: full pressure
  logic signed [57:0] s7_p_q;
  sat_t s7_temp_q;
  // stage 8: outputs
  logic signed [31:0] s8_temp_q, s8_press_q;
  logic               s8_sat_q;

  logic signed [24:0] a_lo, d_lo, b_lo;
  logic signed [22:0] a_hi, d_hi;
  logic signed [27:0] b_hi;
  logic signed [47:0] t_rnd, p_rnd;
  sat_t p_sat;

  assign a_lo  = $signed({1'b0, s3_a_q[23:0]});
  assign a_hi  = s3_a_q[46:24];
  assign d_lo  = $signed({1'b0, s3_d_q[23:0]});
  assign d_hi  = s3_d_q[46:24];
  assign b_lo  = $signed({1'b0, s5_b_q[23:0]});
  assign b_hi  = s5_b_q[51:24];
  assign t_rnd = 48'((s3_t_q + Half15) >>> 16);
  assign p_rnd = 48'((s7_p_q + Half17) >>> 18);
  assign p_sat = sat32(p_rnd);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_pm_q <= raw_pressure_i * ScaleRecip;
      s0_tm_q <= raw_temperature_i * ScaleRecip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_psc_q <= ScW'((s0_pm_q + Half24) >>> 24);
      s1_tsc_q <= ScW'((s0_tm_q + Half24) >>> 24);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s2_m30_q  <= s1_psc_q * coeff_i.c30;
      s2_m21_q  <= s1_psc_q * coeff_i.c21;
      s2_mtp_q  <= s1_tsc_q * s1_psc_q;
      s2_mt1_q  <= s1_tsc_q * coeff_i.c1;
      s2_mt01_q <= s1_tsc_q * coeff_i.c01;
      s2_psc_q  <= s1_psc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s3_a_q    <= (47'(coeff_i.c20) <<< 24) + s2_m30_q;
      s3_d_q    <= (47'(coeff_i.c11) <<< 24) + s2_m21_q;
      s3_e_q    <= 36'((s2_mtp_q + Half24) >>> 24);
      s3_t_q    <= (44'(coeff_i.c0) <<< 23) + 44'(s2_mt1_q);
      s3_mt01_q <= s2_mt01_q;
      s3_psc_q  <= s2_psc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s4_mal_q  <= s3_psc_q * a_lo;
      s4_mah_q  <= s3_psc_q * a_hi;
      s4_mdl_q  <= s3_e_q * d_lo;
      s4_mdh_q  <= s3_e_q * d_hi;
      s4_mt01_q <= s3_mt01_q;
      s4_psc_q  <= s3_psc_q;
      s4_temp_q <= sat32(t_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s5_b_q    <= 52'((56'(coeff_i.c10) <<< 24) + 56'(s4_mah_q)
                       + 56'((s4_mal_q + Half24) >>> 24));
      s5_qed_q  <= 57'(s4_mdh_q) + 57'((s4_mdl_q + Half24) >>> 24);
      s5_mt01_q <= s4_mt01_q;
      s5_psc_q  <= s4_psc_q;
      s5_temp_q <= s4_temp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s6_mbl_q  <= s5_psc_q * b_lo;
      s6_mbh_q  <= s5_psc_q * b_hi;
      s6_sum_q  <= (58'(coeff_i.c00) <<< 24) + 58'(s5_mt01_q) + 58'(s5_qed_q);
      s6_temp_q <= s5_temp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s7_p_q    <= s6_sum_q + 58'(s6_mbh_q) + 58'((s6_mbl_q + Half24) >>> 24);
      s7_temp_q <= s6_temp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s8_temp_q  <= s7_temp_q.value;
      s8_press_q <= p_sat.value;
      s8_sat_q   <= s7_temp_q.clip | p_sat.clip;
    end
  end

  assign temperature_q_o = s8_temp_q;
  assign pressure_q_o    = s8_press_q;
  assign saturated_o     = s8_sat_q;

endmodule

// File: rtl/barometric_pressure_compensation.sv
// Barometric sensor compensation: raw 24-bit pressure/temperature pairs in,
// compensated temperature (1/256 degC) and pressure (1/64 Pa) out.
// Input channel: in_valid_i/in_ready_o with raw_pressure_i, raw_temperature_i.
// Output channel: out_valid_o/out_ready_i with temperature_q_o, pressure_q_o
// and saturated_o (set when either result was clipped to 32 bits).
// Calibration coefficients sit in eight APB registers at byte offsets 0x00
// to 0x1c; pready is tied high, reads return the stored bits. Write them only
// while no beat is in flight.
// Pipeline of nine registered stages (scale multiply, round, coefficient
// products, Horner sums, split 24-bit partial products, final round and
// clip). One beat per cycle is sustained while out_ready_i stays high.
// Each stage has a valid bit; when the receiver stalls, beats pack into
// empty stages and in_ready_o drops only once all nine stages are full.
// Reset clears all valid bits and all coefficient registers to zero.
module barometric_pressure_compensation import bpc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrW-1:0]    paddr,
  input  logic [CfgDataW-1:0]    pwdata,
  output logic [CfgDataW-1:0]    prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [RawW-1:0] raw_pressure_i,
  input  logic signed [RawW-1:0] raw_temperature_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [31:0]     temperature_q_o,
  output logic signed [31:0]     pressure_q_o,
  output logic                   saturated_o
);

  coeff_t               coeff;
  logic [NumStages-1:0] stage_en;

  bpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coeff_o (coeff)
  );

  bpc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stage_en_o  (stage_en)
  );

  bpc_datapath u_dp (
    .clk_i             (clk_i),
    .en_i              (stage_en),
    .coeff_i           (coeff),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .temperature_q_o   (temperature_q_o),
    .pressure_q_o      (pressure_q_o),
    .saturated_o       (saturated_o)
  );

endmodule
